### sv/rtb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtb_pkg: shared types and constants of the reloading timer bank
// Field widths, item mode codes and the structs that pass between the
// sequencer and the timer store.
// ----------------------------------------------------------------------------
package rtb_pkg;

    localparam int unsigned NUM_TIMERS_DEF = 16;
    localparam int unsigned CFG_W          = 5;
    localparam int unsigned IDX_W          = 4;
    localparam int unsigned CNT_W          = 32;
    localparam int unsigned MODE_W         = 2;
    // widest store address and widest channel count over the parameter range
    localparam int unsigned ADDR_W_MAX     = 6;
    localparam int unsigned CHAN_W_MAX     = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_DISARM = 2'd2
    } t_mode;

    typedef struct packed {
        logic                  cnt_we;
        logic                  rel_we;
        logic                  vld_set;
        logic [ADDR_W_MAX-1:0] addr;
        logic [CNT_W-1:0]      cnt;
        logic [CNT_W-1:0]      rel;
    } t_wr_req;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W_MAX-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rel;
    } t_rd_data;

endpackage
`default_nettype wire

### sv/rtb_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtb_mem: timer count and reload store
// Two synchronous arrays with one write and one registered read port.
// Per-entry valid bits make never-armed entries read as zero.
// ----------------------------------------------------------------------------
module rtb_mem import rtb_pkg::*; #(
    parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_wr_req  i_wr,
    input  wire t_rd_req  i_rd,
    output t_rd_data      o_rd
);

    localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [CNT_W-1:0]      mem_cnt [NUM_TIMERS];
    logic [CNT_W-1:0]      mem_rel [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_vld;
    logic [CNT_W-1:0]      r_rd_cnt;
    logic [CNT_W-1:0]      r_rd_rel;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt_we) begin
            mem_cnt[i_wr.addr[AW-1:0]] <= i_wr.cnt;
        end
        if (i_wr.rel_we) begin
            mem_rel[i_wr.addr[AW-1:0]] <= i_wr.rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_cnt <= mem_cnt[i_rd.addr[AW-1:0]];
            r_rd_rel <= mem_rel[i_rd.addr[AW-1:0]];
        end
    end

    // valid bit follows the read so that a held read stays consistent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.vld_set) begin
                r_vld[i_wr.addr[AW-1:0]] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr[AW-1:0]];
            end
        end
    end

    assign o_rd.cnt = r_rd_vld ? r_rd_cnt : '0;
    assign o_rd.rel = r_rd_vld ? r_rd_rel : '0;

endmodule
`default_nettype wire

### sv/reloading_timer_bank_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reloading_timer_bank_unit: bank of down-counting timers with auto reload
// Sequencer that sweeps the timer store once per tick and reports expiries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per item: a
//   tick, an arm (count and reload for one timer) or a disarm. Output
//   channel (o_out_valid / i_out_stall) carries one beat per expiry, with
//   o_last_expiry marking the final expiry of a tick.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes channels_in_use;
//   write it only while the block is idle. It is always ready.
//   Arm, disarm and unused modes are applied on acceptance, without a sweep.
//   A tick sweeps the n channels in use through the single read port of the
//   store: one timer read per cycle while the sweep is not halted, a
//   registered read, an evaluation of each returned entry, and the handover
//   of the last beat; a stalling receiver can lengthen the sweep.
//   The last expiry found is held back one step until the sweep knows
//   whether another follows; a stalled output register halts the sweep
//   once a second expiry is waiting, and the input stays stalled until the
//   sweep ends and the tick's final beat, if any, sits in the output register.
//   Reset (synchronous, active low) stops every timer, clears reload values
//   through per-entry valid bits at once, and sets channels_in_use to zero.
// ----------------------------------------------------------------------------
module reloading_timer_bank_unit import rtb_pkg::*; #(
    parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire logic [IDX_W-1:0]  i_timer_index,
    input  wire logic [CNT_W-1:0]  i_arm_timeout,
    input  wire logic [CNT_W-1:0]  i_arm_reload,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [IDX_W-1:0]       o_expired_index,
    output logic                   o_last_expiry
);

    localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_chan;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic               r_ev_valid, n_ev_valid;
    logic [AW-1:0]      r_ev_idx, n_ev_idx;
    logic               r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic               r_out_last, n_out_last;

    t_wr_req            wr;
    t_rd_req            rd;
    t_rd_data           rd_data;

    logic [CHAN_W_MAX-1:0] chan_lim;
    logic [CW-1:0]         chan_n;
    logic                  in_acc;
    logic                  in_range;
    logic                  out_free;
    logic                  expire;
    logic                  ev_fire;
    logic                  advance;
    logic [CHAN_W_MAX-1:0] ev_idx_w;

    // clamp channels in use to the bank size
    always_comb begin
        if (CHAN_W_MAX'(r_chan) > CHAN_W_MAX'(NUM_TIMERS)) begin
            chan_lim = CHAN_W_MAX'(NUM_TIMERS);
        end else begin
            chan_lim = CHAN_W_MAX'(r_chan);
        end
    end
    assign chan_n = chan_lim[CW-1:0];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign in_range    = CHAN_W_MAX'(i_timer_index) < chan_lim;

    // output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign expire   = (rd_data.cnt == CNT_W'(1));
    // an expiry can only retire if the held one has somewhere to go
    assign ev_fire  = r_ev_valid && (!expire || !r_pend_valid || out_free);
    assign advance  = !r_ev_valid || ev_fire;
    assign ev_idx_w = CHAN_W_MAX'(r_ev_idx);

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_ev_valid   = r_ev_valid;
        n_ev_idx     = r_ev_idx;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        wr           = '0;
        rd           = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (t_mode'(i_mode))
                        MODE_TICK: begin
                            n_state = ST_SWEEP;
                            n_ptr   = '0;
                        end
                        MODE_ARM: begin
                            if (in_range) begin
                                wr.cnt_we  = 1'b1;
                                wr.rel_we  = 1'b1;
                                wr.vld_set = 1'b1;
                                wr.addr    = ADDR_W_MAX'(i_timer_index);
                                wr.cnt     = i_arm_timeout;
                                wr.rel     = i_arm_reload;
                            end
                        end
                        MODE_DISARM: begin
                            // a never-armed entry already reads as zero
                            if (in_range) begin
                                wr.cnt_we = 1'b1;
                                wr.addr   = ADDR_W_MAX'(i_timer_index);
                                wr.cnt    = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // evaluate the entry whose read data has returned
                if (ev_fire) begin
                    wr.cnt_we = (rd_data.cnt != '0);
                    wr.addr   = ADDR_W_MAX'(r_ev_idx);
                    wr.cnt    = expire ? rd_data.rel : (rd_data.cnt - CNT_W'(1));
                    if (expire) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_idx   = r_pend_idx;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = ev_idx_w[IDX_W-1:0];
                    end
                end
                // issue the next read, or drain the evaluation stage
                if (advance) begin
                    if (r_ptr < chan_n) begin
                        rd.en      = 1'b1;
                        rd.addr    = ADDR_W_MAX'(r_ptr[AW-1:0]);
                        n_ev_valid = 1'b1;
                        n_ev_idx   = r_ptr[AW-1:0];
                        n_ptr      = r_ptr + CW'(1);
                    end else begin
                        n_ev_valid = 1'b0;
                    end
                end
                // sweep done: hand the held expiry over as the last beat
                if (!r_ev_valid && (r_ptr == chan_n)) begin
                    if (!r_pend_valid) begin
                        n_state = ST_IDLE;
                    end else if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_idx    = r_pend_idx;
                        n_out_last   = 1'b1;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_chan       <= '0;
            r_ptr        <= '0;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_ev_valid   <= n_ev_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_chan <= i_cfg_data;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_ev_idx   <= n_ev_idx;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    rtb_mem #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_rd    (rd_data)
    );

    assign o_out_valid     = r_out_valid;
    assign o_expired_index = r_out_idx;
    assign o_last_expiry   = r_out_last;

endmodule
`default_nettype wire

### tb/reloading_timer_bank_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reloading_timer_bank_unit_tb: self-checking bench for the timer bank
// Drives tick, arm, disarm and unused-mode beats with random gaps on both
// channels, keeps its own copy of every timer's count and reload value, and
// compares each expiry beat with the oldest predicted one. Directed tests
// cover reset state, one-shot and reload, channel limits and a full sweep;
// random phases then run at several channel counts.
// ----------------------------------------------------------------------------
module reloading_timer_bank_unit_tb;
    import rtb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;
    localparam int unsigned       BANK_SIZE     = NUM_TIMERS_DEF;
    // a tick with nothing expiring still sweeps every channel in use
    localparam int unsigned       SETTLE_CYCLES = 24;
    localparam int unsigned       RANDOM_ITEMS  = 350;
    localparam int unsigned       PHASE_ITEMS   = 50;
    localparam int unsigned       MAX_REPORTS   = 10;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic             last;
    } t_expiry;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [MODE_W-1:0] i_mode;
    logic [IDX_W-1:0]  i_timer_index;
    logic [CNT_W-1:0]  i_arm_timeout;
    logic [CNT_W-1:0]  i_arm_reload;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [IDX_W-1:0]  o_expired_index;
    logic              o_last_expiry;

    // shadow of the timer bank
    logic [CNT_W-1:0] count_shadow  [BANK_SIZE];
    logic [CNT_W-1:0] reload_shadow [BANK_SIZE];
    logic [CFG_W-1:0] channels_shadow;

    t_expiry     expiry_q[$];
    int unsigned mismatch_count;
    int unsigned items_applied;
    int unsigned in_gap_max;
    int unsigned out_gap_max;

    reloading_timer_bank_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_timer_index   (i_timer_index),
        .i_arm_timeout   (i_arm_timeout),
        .i_arm_reload    (i_arm_reload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expired_index (o_expired_index),
        .o_last_expiry   (o_last_expiry)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp the register to the size of the bank, as the block does.
    function automatic int unsigned timers_in_use();
        int unsigned n;
        n = channels_shadow;
        if (n > BANK_SIZE) n = BANK_SIZE;
        return n;
    endfunction

    // Apply one accepted beat to the shadow bank and queue the expiries it
    // causes. Return 1 for a tick and for an arm or disarm in range.
    function automatic bit advance_timer_bank(input logic [MODE_W-1:0] mode,
                                              input logic [IDX_W-1:0]  index,
                                              input logic [CNT_W-1:0]  timeout,
                                              input logic [CNT_W-1:0]  reload);
        int unsigned n;
        int          last_pos;
        t_expiry     hit;
        n        = timers_in_use();
        last_pos = -1;
        case (mode)
            MODE_ARM: begin
                if (index >= n) return 1'b0;
                count_shadow[index]  = timeout;
                reload_shadow[index] = reload;
                return 1'b1;
            end
            MODE_DISARM: begin
                if (index >= n) return 1'b0;
                count_shadow[index] = '0;
                return 1'b1;
            end
            MODE_TICK: begin
                for (int unsigned t = 0; t < n; t++) begin
                    if (count_shadow[t] != '0) begin
                        count_shadow[t] = count_shadow[t] - 1'b1;
                        if (count_shadow[t] == '0) begin
                            hit.index = IDX_W'(t);
                            hit.last  = 1'b0;
                            expiry_q.push_back(hit);
                            last_pos = expiry_q.size() - 1;
                            count_shadow[t] = reload_shadow[t];
                        end
                    end
                end
                // only the final expiry of this tick carries the mark
                if (last_pos >= 0) expiry_q[last_pos].last = 1'b1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking: compare every accepted expiry beat with the oldest one due
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_expiry due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expiry_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected expiry beat: index %0d last %0b",
                             o_expired_index, o_last_expiry);
            end else begin
                due = expiry_q.pop_front();
                if (o_expired_index !== due.index || o_last_expiry !== due.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("expiry mismatch: expected index %0d last %0b, got index %0d last %0b",
                                 due.index, due.last, o_expired_index, o_last_expiry);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: hold stall for a random number of cycles before each beat
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            hold = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Sender and configuration helpers
    // ------------------------------------------------------------------

    // Send one beat after a random gap and update the shadow on acceptance.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [IDX_W-1:0]  index,
                             input logic [CNT_W-1:0]  timeout,
                             input logic [CNT_W-1:0]  reload);
        int unsigned gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_timer_index <= index;
        i_arm_timeout <= timeout;
        i_arm_reload  <= reload;
        do @(posedge i_clk); while (o_in_stall);
        void'(advance_timer_bank(mode, index, timeout, reload));
        items_applied++;
    endtask

    // Drop valid and hold the sender until every predicted expiry is in.
    task automatic wait_expiries_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expiry_q.size() != 0);
    endtask

    // Drain, let a silent sweep finish, then write channels_in_use.
    task automatic write_channels(input logic [CFG_W-1:0] value);
        wait_expiries_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid     <= 1'b0;
        channels_shadow  = value;
    endtask

    // Mostly small counts so that timers expire, sometimes the full range.
    function automatic logic [CNT_W-1:0] pick_count();
        if ($urandom_range(0, 9) < 7) return CNT_W'($urandom_range(0, 5));
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register is zero after reset: nothing is visited and arms are dropped.
    task automatic test_reset_defaults();
        send_item(MODE_TICK, 4'd0, '0, '0);
        send_item(MODE_ARM,  4'd0, 32'd1, 32'd0);
        send_item(MODE_TICK, 4'd0, '0, '0);
    endtask

    // One-shot, reload, stopped timers, unused mode and disarm.
    task automatic test_one_shot_and_reload();
        write_channels(CFG_W'(BANK_SIZE));
        send_item(MODE_ARM,    4'd0,  32'd1, 32'd0);
        send_item(MODE_ARM,    4'd15, 32'd1, 32'd2);
        send_item(MODE_ARM,    4'd7,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_UNUSED, 4'd5,  32'd1, 32'd1);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        send_item(MODE_DISARM, 4'd15, '0, '0);
        send_item(MODE_DISARM, 4'd7,  '0, '0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
    endtask

    // Register above the bank size, and indexes beyond the channels in use.
    task automatic test_channel_limits();
        write_channels(5'd31);
        send_item(MODE_ARM,    4'd15, 32'd1, 32'd0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        write_channels(5'd1);
        send_item(MODE_ARM,    4'd1,  32'd1, 32'd0);
        send_item(MODE_DISARM, 4'd15, '0, '0);
        send_item(MODE_ARM,    4'd0,  32'd2, 32'd1);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
        send_item(MODE_DISARM, 4'd0,  '0, '0);
        send_item(MODE_TICK,   4'd0,  '0, '0);
    endtask

    // Every timer expires on the same tick: the longest burst of beats.
    task automatic test_full_sweep();
        write_channels(CFG_W'(BANK_SIZE));
        for (int unsigned t = 0; t < BANK_SIZE; t++)
            send_item(MODE_ARM, IDX_W'(t), 32'd1, 32'd1);
        send_item(MODE_TICK, 4'd0, '0, '0);
        send_item(MODE_TICK, 4'd0, '0, '0);
    endtask

    // Hold the sender until the expiries of a tick are all in, then go on.
    task automatic test_held_sender();
        send_item(MODE_ARM,  4'd3, 32'd1, 32'd0);
        send_item(MODE_TICK, 4'd0, '0, '0);
        wait_expiries_drained();
        send_item(MODE_TICK, 4'd0, '0, '0);
    endtask

    // Random phases at varied channel counts and idling.
    task automatic test_random_traffic();
        int unsigned       phase;
        int unsigned       pick;
        int unsigned       n;
        logic [CFG_W-1:0]  chans;
        logic [IDX_W-1:0]  index;
        items_applied = 0;
        phase         = 0;
        while (items_applied < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       chans = 5'd0;
                1:       chans = CFG_W'(BANK_SIZE);
                2:       chans = CFG_W'($urandom_range(BANK_SIZE + 1, 31));
                default: chans = CFG_W'($urandom_range(1, BANK_SIZE));
            endcase
            write_channels(chans);
            // every third phase runs with no idling on either side
            in_gap_max  = (phase % 3 == 2) ? 0 : 10;
            out_gap_max = in_gap_max;
            n = timers_in_use();
            for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
                if (n > 0 && $urandom_range(0, 9) < 9)
                    index = IDX_W'($urandom_range(0, n - 1));
                else
                    index = IDX_W'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    send_item(MODE_TICK, IDX_W'($urandom), $urandom, $urandom);
                else if (pick < 82)
                    send_item(MODE_ARM, index, pick_count(),
                              ($urandom_range(0, 1) == 0) ? '0 : pick_count());
                else if (pick < 95)
                    send_item(MODE_DISARM, index, $urandom, $urandom);
                else
                    send_item(MODE_UNUSED, index, $urandom, $urandom);
                if ($urandom_range(0, 99) < 3) wait_expiries_drained();
            end
            phase++;
        end
        in_gap_max  = 10;
        out_gap_max = 10;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_TICK;
        i_timer_index   = '0;
        i_arm_timeout   = '0;
        i_arm_reload    = '0;
        i_out_stall     = 1'b0;
        mismatch_count  = 0;
        items_applied   = 0;
        in_gap_max      = 10;
        out_gap_max     = 10;
        channels_shadow = '0;
        for (int unsigned t = 0; t < BANK_SIZE; t++) begin
            count_shadow[t]  = '0;
            reload_shadow[t] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_one_shot_and_reload();
        test_channel_limits();
        test_full_sweep();
        test_held_sender();
        test_random_traffic();

        wait_expiries_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expiry_q.size() != 0) begin
            mismatch_count++;
            $display("%0d expiries never arrived", expiry_q.size());
        end

        if (mismatch_count == 0)
            $display("reloading_timer_bank_unit: match");
        else
            $display("reloading_timer_bank_unit: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(8 * 600000);
        $display("reloading_timer_bank_unit: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
